FILE: hw/rtl/mwd_pkg.sv
package mwd_pkg;

	// Width of every word field on the ports.
	localparam int FIELD_BITS = 64;

	typedef logic [FIELD_BITS-1:0] word_t;

	// One dividend limb as it arrives on the input channel.
	typedef struct packed {
		word_t limb_value;
		word_t divisor_value;
		logic  first_limb;
		logic  last_limb;
	} limb_t;

	// One quotient limb with the remainder after it.
	typedef struct packed {
		word_t quotient_limb;
		word_t running_remainder;
		logic  is_last;
		logic  divide_by_zero;
	} result_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic clear;
		logic emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_zero;
		logic last_step;
		logic out_free;
	} status_t;

endpackage

FILE: hw/rtl/multiword_by_word_divider.sv
// Channel   Payload             Handshake              Direction
// limb      mwd_pkg::limb_t     limb_valid/limb_stall  into the block
// result    mwd_pkg::result_t   result_valid/result_stall  out of the block
//
// Each limb is loaded, then divided one quotient bit per step in the
// radix-2 restoring divide loop, and then written to the output register.
// A zero divisor skips the loop.
// Reset clears the running remainder and the held divisor to zero.
// The output register holds a result while result_stall is high; the next
// limb is taken and divided meanwhile, and waits only to be written out.
module multiword_by_word_divider #(
	parameter int WORD_BITS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             limb_valid,
	output logic             limb_stall,
	input  mwd_pkg::limb_t   limb_data,
	output logic             result_valid,
	input  logic             result_stall,
	output mwd_pkg::result_t result_data
);

	mwd_pkg::cmd_t    cmd;
	mwd_pkg::status_t status;

	// Sequencer for load, divide loop and output write.
	mwd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.limb_valid (limb_valid),
		.limb_stall (limb_stall),
		.status     (status),
		.cmd        (cmd)
	);

	// Remainder, divisor, shift register and output register.
	mwd_dpath #(
		.WORD_BITS (WORD_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.limb_data    (limb_data),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result_data  (result_data),
		.cmd          (cmd),
		.status       (status)
	);

endmodule

FILE: hw/rtl/mwd_ctrl.sv
module mwd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             limb_valid,
	output logic             limb_stall,
	input  mwd_pkg::status_t status,
	output mwd_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CALC = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// The block takes a limb only while no division is in flight.
	assign limb_stall = (state_q != ST_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (limb_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CALC;
				end
			end
			ST_CALC: begin
				if (status.div_zero) begin
					cmd.clear = 1'b1;
					state_d   = ST_HOLD;
				end else begin
					cmd.step = 1'b1;
					if (status.last_step) begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// A limb transfer always starts a division.
	assert property (@(posedge clk) disable iff (!arst_n)
		(limb_valid && !limb_stall) |=> (state_q == ST_CALC))
		else $error("limb transfer did not start a division");

endmodule

FILE: hw/rtl/mwd_dpath.sv
module mwd_dpath #(
	parameter int WORD_BITS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mwd_pkg::limb_t   limb_data,
	input  logic             result_stall,
	output logic             result_valid,
	output mwd_pkg::result_t result_data,
	input  mwd_pkg::cmd_t    cmd,
	output mwd_pkg::status_t status
);

	localparam int CW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

	logic [WORD_BITS-1:0] rem_q;
	logic [WORD_BITS-1:0] div_q;
	logic [WORD_BITS-1:0] lo_q;
	logic [CW-1:0]        cnt_q;
	logic                 last_q;
	logic                 out_valid_q;
	mwd_pkg::result_t     out_q;

	logic [WORD_BITS-1:0] shifted;
	logic [WORD_BITS-1:0] diff;
	logic                 take;

	// One restoring step: shift in the next dividend bit, subtract when it fits.
	assign shifted = {rem_q[WORD_BITS-2:0], lo_q[WORD_BITS-1]};
	assign diff    = shifted - div_q;
	assign take    = rem_q[WORD_BITS-1] || (shifted >= div_q);

	assign status.div_zero  = (div_q == '0);
	assign status.last_step = (cnt_q == '0);
	assign status.out_free  = !out_valid_q || !result_stall;

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

	// Running remainder and held divisor; both reset to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			div_q <= '0;
		end else if (cmd.load) begin
			if (limb_data.first_limb) begin
				div_q <= limb_data.divisor_value[WORD_BITS-1:0];
				rem_q <= '0;
			end
		end else if (cmd.clear) begin
			rem_q <= '0;
		end else if (cmd.step) begin
			rem_q <= take ? diff : shifted;
		end
	end

	// Dividend shift register; quotient bits enter from the bottom.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q   <= limb_data.limb_value[WORD_BITS-1:0];
			cnt_q  <= CW'(WORD_BITS - 1);
			last_q <= limb_data.last_limb;
		end else if (cmd.clear) begin
			lo_q <= '0;
		end else if (cmd.step) begin
			lo_q  <= {lo_q[WORD_BITS-2:0], take};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.quotient_limb     <= mwd_pkg::word_t'(lo_q);
			out_q.running_remainder <= mwd_pkg::word_t'(rem_q);
			out_q.is_last           <= last_q;
			out_q.divide_by_zero    <= (div_q == '0);
		end
	end

	// Output register valid: set on a new result, dropped after its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// The remainder stays below a nonzero divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(div_q != '0) |-> (rem_q < div_q))
		else $error("running remainder not below divisor");

	// A division step never runs with a zero divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (div_q != '0))
		else $error("division step with zero divisor");

	// A zero-divisor result carries zero quotient and remainder.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.divide_by_zero) |->
		((out_q.quotient_limb == '0) && (out_q.running_remainder == '0)))
		else $error("zero-divisor result not cleared");

	// A new result is never written over one still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !result_stall))
		else $error("result overwritten while stalled");

endmodule
